[sv/sync_length_checksum_frame_parser_macros.svh]
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/slcfp_pkg.sv]
package slcfp_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 64;

  localparam logic [7:0] SYNC_BYTE     = 8'hAA;
  localparam logic [7:0] SYNC_PAIR_SUM = SYNC_BYTE + SYNC_BYTE;
  localparam logic [7:0] LEN_CAP       = 8'd64;
  localparam logic [6:0] LIMIT_RESET   = 7'd51;

  // configuration register indexes
  localparam logic CFG_LENGTH_LIMIT    = 1'b0;
  localparam logic CFG_CHECKSUM_ENABLE = 1'b1;

  // frame_status codes
  localparam logic [1:0] ST_WORD   = 2'd0;
  localparam logic [1:0] ST_CSUM   = 2'd1;
  localparam logic [1:0] ST_NOWORD = 2'd2;

  typedef enum logic [3:0] {
    S_SYNC1,
    S_SYNC2,
    S_FUNC,
    S_LEN,
    S_DATA,
    S_CHECK,
    S_RD_HI,
    S_RD_LO,
    S_PUSH,
    S_ERR,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic ld_func;
    logic ld_len;
    logic wr_byte;
    logic ld_hi;
    logic rd_lo;
    logic push_word;
    logic push_err;
    logic push_empty;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_ok;
    logic len_zero;
    logic data_last;
    logic sum_match;
    logic cs_en;
    logic words_zero;
    logic word_last;
    logic out_free;
  } stat_t;

endpackage

[sv/slcfp_ram.sv]
module slcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/slcfp_ctrl.sv]
module slcfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slcfp_pkg::stat_t    stat,
  output slcfp_pkg::cmd_t     cmd
);
  import slcfp_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SYNC1: if (acc && stat.is_sync) state_nxt = S_SYNC2;
      S_SYNC2: if (acc) state_nxt = stat.is_sync ? S_FUNC : S_SYNC1;
      S_FUNC:  if (acc) state_nxt = S_LEN;
      S_LEN: begin
        if (acc) begin
          if (!stat.len_ok)       state_nxt = S_SYNC1;
          else if (stat.len_zero) state_nxt = S_CHECK;
          else                    state_nxt = S_DATA;
        end
      end
      S_DATA:  if (acc && stat.data_last) state_nxt = S_CHECK;
      S_CHECK: begin
        if (acc) begin
          if (stat.cs_en && !stat.sum_match) state_nxt = S_ERR;
          else if (stat.words_zero)          state_nxt = S_EMPTY;
          else                               state_nxt = S_RD_HI;
        end
      end
      S_RD_HI: state_nxt = S_RD_LO;
      S_RD_LO: state_nxt = S_PUSH;
      S_PUSH: begin
        if (stat.out_free) state_nxt = stat.word_last ? S_SYNC1 : S_RD_HI;
      end
      S_ERR, S_EMPTY: if (stat.out_free) state_nxt = S_SYNC1;
      default: state_nxt = S_SYNC1;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_SYNC1, S_SYNC2, S_CHECK: in_ready = 1'b1;
      S_FUNC: begin
        in_ready    = 1'b1;
        cmd.ld_func = acc;
      end
      S_LEN: begin
        in_ready   = 1'b1;
        cmd.ld_len = acc && stat.len_ok;
      end
      S_DATA: begin
        in_ready    = 1'b1;
        cmd.wr_byte = acc;
      end
      S_RD_HI: ;
      S_RD_LO: begin
        cmd.ld_hi = 1'b1;
        cmd.rd_lo = 1'b1;
      end
      S_PUSH: begin
        cmd.rd_lo     = 1'b1;  // hold the read so the low byte stays put
        cmd.push_word = stat.out_free;
      end
      S_ERR:   cmd.push_err   = stat.out_free;
      S_EMPTY: cmd.push_empty = stat.out_free;
      default: ;
    endcase
  end

endmodule

[sv/slcfp_dpath.sv]
module slcfp_dpath #(
  parameter int PAYLOAD_DEPTH = slcfp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_rx_byte,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  input  slcfp_pkg::cmd_t     cmd,
  output slcfp_pkg::stat_t    stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_frame_function,
  output logic [4:0]          out_word_index,
  output logic signed [15:0]  out_word_value,
  output logic [1:0]          out_frame_status,
  output logic                out_last_of_frame
);
  import slcfp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam int IW = (AW > 6) ? AW : 6;

  logic [6:0] limit_r;
  logic       cs_en_r;
  logic [7:0] func_r;
  logic [5:0] len_r;
  logic [5:0] rcv_r;
  logic [7:0] sum_r;
  logic [4:0] word_r;
  logic [7:0] hi_r;

  logic              out_valid_r;
  logic [7:0]        out_func_r;
  logic [4:0]        out_idx_r;
  logic [15:0]       out_val_r;
  logic [1:0]        out_st_r;
  logic              out_last_r;

  logic [IW-1:0] wr_wide, rd_wide;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic [5:0]    rcv_inc;
  logic          push_any;

  assign wr_wide = IW'(rcv_r);
  assign rd_wide = IW'({word_r, cmd.rd_lo});
  assign waddr   = wr_wide[AW-1:0];
  assign raddr   = rd_wide[AW-1:0];
  assign rcv_inc = rcv_r + 6'd1;

  slcfp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_byte),
    .waddr (waddr),
    .wdata (in_rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      cs_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH_LIMIT:    limit_r <= cfg_wdata;
        CFG_CHECKSUM_ENABLE: cs_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r <= '0;
      len_r  <= '0;
      rcv_r  <= '0;
      sum_r  <= '0;
      word_r <= '0;
    end else begin
      if (cmd.ld_func) begin
        func_r <= in_rx_byte;
        sum_r  <= SYNC_PAIR_SUM + in_rx_byte;
      end
      if (cmd.ld_len) begin
        len_r  <= in_rx_byte[5:0];
        rcv_r  <= '0;
        word_r <= '0;
        sum_r  <= sum_r + in_rx_byte;
      end
      if (cmd.wr_byte) begin
        rcv_r <= rcv_inc;
        sum_r <= sum_r + in_rx_byte;
      end
      if (cmd.push_word) begin
        word_r <= word_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_hi) begin
      hi_r <= rdata;
    end
  end

  assign push_any = cmd.push_word || cmd.push_err || cmd.push_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      out_func_r <= func_r;
      if (cmd.push_word) begin
        out_idx_r  <= word_r;
        out_val_r  <= {hi_r, rdata};
        out_st_r   <= ST_WORD;
        out_last_r <= stat.word_last;
      end else begin
        out_idx_r  <= '0;
        out_val_r  <= '0;
        out_st_r   <= cmd.push_err ? ST_CSUM : ST_NOWORD;
        out_last_r <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.is_sync    = (in_rx_byte == SYNC_BYTE);
    stat.len_ok     = ({1'b0, in_rx_byte} < {2'b00, limit_r}) &&
                      ({1'b0, in_rx_byte} < 9'(PAYLOAD_DEPTH)) &&
                      (in_rx_byte < LEN_CAP);
    stat.len_zero   = (in_rx_byte == 8'd0);
    stat.data_last  = (rcv_inc == len_r);
    stat.sum_match  = (in_rx_byte == sum_r);
    stat.cs_en      = cs_en_r;
    stat.words_zero = (len_r[5:1] == 5'd0);
    stat.word_last  = ((word_r + 5'd1) == len_r[5:1]);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_function = out_func_r;
  assign out_word_index     = out_idx_r;
  assign out_word_value     = out_val_r;
  assign out_frame_status   = out_st_r;
  assign out_last_of_frame  = out_last_r;

endmodule

[sv/sync_length_checksum_frame_parser.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready    in_rx_byte
// out       output     out_valid / out_ready  function, index, value, status, last
// cfg       input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One byte per cycle is taken, the checksum byte included. After the checksum passes
// (or checking is off) the payload store drains word by word via S_RD_HI, S_RD_LO and
// S_PUSH (two reads of its single read port plus the output load), stalling while
// out_ready is low, taking no byte. A status result waits for a free output.
// Reset is synchronous; the payload store is not cleared and needs no clearing pass.
`include "sync_length_checksum_frame_parser_macros.svh"

module sync_length_checksum_frame_parser #(
  parameter int PAYLOAD_DEPTH = slcfp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_function,
  output logic [4:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic [1:0]         out_frame_status,
  output logic               out_last_of_frame,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata
);
  import slcfp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slcfp_dpath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_rx_byte         (in_rx_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_function (out_frame_function),
    .out_word_index     (out_word_index),
    .out_word_value     (out_word_value),
    .out_frame_status   (out_frame_status),
    .out_last_of_frame  (out_last_of_frame)
  );

  `SLCFP_ASSERT_NOW(a_status_shape, out_valid && (out_frame_status != ST_WORD), out_last_of_frame && (out_word_index == 5'd0) && (out_word_value == 16'sd0), "status result must be a lone zero result")
  `SLCFP_ASSERT_NOW(a_push_free, cmd.push_word || cmd.push_err || cmd.push_empty, stat.out_free, "result pushed into a full output register")
  `SLCFP_ASSERT_NOW(a_push_one, 1'b1, $onehot0({cmd.push_word, cmd.push_err, cmd.push_empty}), "more than one result pushed at once")
  `SLCFP_ASSERT_NEXT(a_push_shows, cmd.push_word || cmd.push_err || cmd.push_empty, out_valid, "pushed result not shown on the output")

endmodule
